// ===== sv/assert_macros.svh =====
// Assertion macros shared by the glyph cache tag engine RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Checked on every rising edge outside reset.
`define GCL_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("glyph cache tag engine assertion failed");
// Checked on every rising edge, reset included.
`define GCL_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("glyph cache tag engine assertion failed");
`else
`define GCL_ASSERT(lbl, prop)
`define GCL_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

// ===== sv/gcl_pkg.sv =====
// Types and constants of the glyph cache tag engine.
package gcl_pkg;

  // Table geometry; both are powers of two, so the home slot is a mask of the hash.
  localparam int unsigned ENTRIES = 256;
  localparam int unsigned BUCKETS = 256;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FIND_RD,
    ST_FIND_CMP,
    ST_EVICT_RD,
    ST_EVICT_CMP,
    ST_EVICT_DROP,
    ST_HASH_MUL,
    ST_PROBE,
    ST_INSERT,
    ST_DONE
  } state_e;

  // Operation codes.
  typedef enum logic [1:0] {
    KIND_LOOKUP = 2'd0,
    KIND_INSERT = 2'd1,
    KIND_CLEAR  = 2'd2,
    KIND_RSVD   = 2'd3
  } kind_e;

  // Result codes.
  typedef enum logic [2:0] {
    STS_MISS      = 3'd0,
    STS_HIT       = 3'd1,
    STS_INSERTED  = 3'd2,
    STS_PRESENT   = 3'd3,
    STS_TOO_LARGE = 3'd4,
    STS_CLEARED   = 3'd5
  } status_e;

  // Register index of the byte budget (address bit 2).
  localparam logic REG_MEMORY_LIMIT = 1'b0;

  localparam logic [24:0] LIMIT_RESET = 25'd4194304;
  localparam logic [63:0] MIX_A       = 64'hff51afd7ed558ccd;
  localparam logic [63:0] MIX_B       = 64'hc4ceb9fe1a85ec53;
  localparam int unsigned MIX_SHIFT   = 33;
  // Eviction takes a quarter of the entries: a shift by two.
  localparam int unsigned EVICT_SHIFT = 2;

  // One tag memory word.
  typedef struct packed {
    logic [63:0] key;
    logic [63:0] stamp;
    logic [20:0] bytes;
  } entry_t;

endpackage

// ===== sv/glyph_cache_lru_tag_engine_core.sv =====
// Glyph cache tag engine: LRU tag table with hashed placement and eviction.
//
//  channel | direction | handshake                 | beat
//  --------+-----------+---------------------------+------------------------------------
//  in      | to core   | in_valid_i / in_stall_o   | kind, font_size, codepoint, w, h, bm
//  out     | from core | out_valid_o / out_stall_i | status, evicted, entries, bytes
//  apb     | to core   | psel/penable/pwrite/pready| memory_limit at byte address 0
//
// One item at a time. A lookup or insert scans the tag memory, a read state and a
// compare state per entry; a hit ends the scan early, else the whole table is read.
// An insert adds a full scan and one drop state for each evicted entry, a hash of
// two multiplies, a linear probe of up to ENTRIES slots and one write state.
// Clear and the reserved code need no scan. Reset clears the valid bits at once,
// with no clearing pass. A stalled result holds the core in its final state.
module glyph_cache_lru_tag_engine_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  kind_i,
  input  logic [31:0] font_size_i,
  input  logic [31:0] codepoint_i,
  input  logic [9:0]  glyph_width_i,
  input  logic [9:0]  glyph_height_i,
  input  logic        has_bitmap_i,
  // Output channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic [6:0]  evicted_count_o,
  output logic [8:0]  entries_in_use_o,
  output logic [31:0] bytes_in_use_o,
  // Configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import gcl_pkg::*;

  localparam int unsigned IW   = $clog2(ENTRIES);
  localparam int unsigned CW   = $clog2(ENTRIES + 1);
  localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);

  // Control state
  state_e            state_q, state_d;
  logic [24:0]       limit_q, limit_d;
  logic [ENTRIES-1:0] valid_q, valid_d;
  logic [63:0]       use_clock_q, use_clock_d;
  logic [31:0]       bytes_total_q, bytes_total_d;
  logic [CW-1:0]     entry_total_q, entry_total_d;
  logic              out_valid_q, out_valid_d;

  // Item and working registers
  kind_e             kind_q;
  logic [63:0]       key_q;
  logic [9:0]        gw_q, gh_q;
  logic              bm_q;
  logic [IW-1:0]     idx_q, idx_d;
  logic [IW-1:0]     step_q, step_d;
  status_e           res_status_q, res_status_d;
  logic [CW-1:0]     evcnt_q, evcnt_d;
  logic [CW-1:0]     rounds_q, rounds_d;
  logic              best_vld_q, best_vld_d;
  logic [IW-1:0]     best_idx_q, best_idx_d;
  logic [63:0]       best_stamp_q, best_stamp_d;
  logic [20:0]       best_bytes_q, best_bytes_d;
  logic [63:0]       hash_q, hash_d;
  logic [63:0]       acc_q, acc_d;
  logic [63:0]       prod_q, prod_d;
  logic [1:0]        phase_q, phase_d;
  logic              mstep_q, mstep_d;

  // Output registers
  status_e           out_status_q;
  logic [6:0]        out_evict_q;
  logic [8:0]        out_entries_q;
  logic [31:0]       out_bytes_q;
  logic              out_load;

  // Tag memory
  entry_t            mem_q [ENTRIES];
  entry_t            rdata_q;
  logic              mem_re, mem_we;
  logic [IW-1:0]     mem_raddr, mem_waddr;
  entry_t            mem_wdata;

  // Helper terms
  logic              in_accept;
  logic [19:0]       gsize;
  logic [20:0]       cnt_bytes;
  logic [32:0]       over_sum;
  logic [32:0]       add_sum;
  logic [31:0]       mul_a, mul_b;
  logic [63:0]       mix_const;
  logic [63:0]       mul_fin;
  logic [63:0]       mix_next;
  logic [CW-1:0]     quarter;
  logic              key_hit;

  assign in_accept = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != ST_IDLE);
  assign pready    = 1'b1;
  assign prdata    = (paddr[2] == REG_MEMORY_LIMIT) ? {7'd0, limit_q} : 32'd0;

  assign out_valid_o      = out_valid_q;
  assign status_o         = out_status_q;
  assign evicted_count_o  = out_evict_q;
  assign entries_in_use_o = out_entries_q;
  assign bytes_in_use_o   = out_bytes_q;

  // Glyph size and the byte count charged to the entry.
  assign gsize     = 20'(gw_q) * 20'(gh_q);
  assign cnt_bytes = bm_q ? 21'(gsize) : 21'd0;
  assign over_sum  = {1'b0, bytes_total_q} + 33'(gsize);
  assign add_sum   = {1'b0, bytes_total_q} + 33'(cnt_bytes);
  assign quarter   = entry_total_q >> EVICT_SHIFT;
  assign key_hit   = valid_q[idx_q] && (rdata_q.key == key_q);

  // Shared 32x32 multiplier for the low half of each 64-bit mix product.
  assign mix_const = mstep_q ? MIX_B : MIX_A;
  assign mul_a     = (phase_q == 2'd2) ? hash_q[63:32] : hash_q[31:0];
  assign mul_b     = (phase_q == 2'd1) ? mix_const[63:32] : mix_const[31:0];
  assign mul_fin   = {acc_q[63:32] + prod_q[31:0], acc_q[31:0]};
  assign mix_next  = mul_fin ^ (mul_fin >> MIX_SHIFT);

  // Next state and datapath control.
  always_comb begin
    state_d       = state_q;
    limit_d       = limit_q;
    valid_d       = valid_q;
    use_clock_d   = use_clock_q;
    bytes_total_d = bytes_total_q;
    entry_total_d = entry_total_q;
    idx_d         = idx_q;
    step_d        = step_q;
    res_status_d  = res_status_q;
    evcnt_d       = evcnt_q;
    rounds_d      = rounds_q;
    best_vld_d    = best_vld_q;
    best_idx_d    = best_idx_q;
    best_stamp_d  = best_stamp_q;
    best_bytes_d  = best_bytes_q;
    hash_d        = hash_q;
    acc_d         = acc_q;
    prod_d        = prod_q;
    phase_d       = phase_q;
    mstep_d       = mstep_q;
    mem_re        = 1'b0;
    mem_raddr     = idx_q;
    mem_we        = 1'b0;
    mem_waddr     = idx_q;
    mem_wdata     = '0;
    out_load      = 1'b0;

    // Register write from the configuration port.
    if (psel && penable && pwrite && (paddr[2] == REG_MEMORY_LIMIT)) begin
      limit_d = pwdata[24:0];
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          idx_d   = '0;
          evcnt_d = '0;
          unique case (kind_e'(kind_i))
            KIND_LOOKUP, KIND_INSERT: begin
              state_d = ST_FIND_RD;
            end
            KIND_CLEAR: begin
              valid_d       = '0;
              entry_total_d = '0;
              bytes_total_d = '0;
              res_status_d  = STS_CLEARED;
              state_d       = ST_DONE;
            end
            default: begin
              res_status_d = STS_MISS;
              state_d      = ST_DONE;
            end
          endcase
        end
      end

      // Search the whole table for the key.
      ST_FIND_RD: begin
        mem_re  = 1'b1;
        state_d = ST_FIND_CMP;
      end

      ST_FIND_CMP: begin
        if (key_hit) begin
          if (kind_q == KIND_LOOKUP) begin
            use_clock_d     = use_clock_q + 64'd1;
            mem_we          = 1'b1;
            mem_wdata.key   = rdata_q.key;
            mem_wdata.stamp = use_clock_q + 64'd1;
            mem_wdata.bytes = rdata_q.bytes;
            res_status_d    = STS_HIT;
          end else begin
            res_status_d = STS_PRESENT;
          end
          state_d = ST_DONE;
        end else if (idx_q != LAST_IDX) begin
          idx_d   = idx_q + 1'b1;
          state_d = ST_FIND_RD;
        end else if (kind_q == KIND_LOOKUP) begin
          res_status_d = STS_MISS;
          state_d      = ST_DONE;
        end else if (25'(gsize) > limit_q) begin
          res_status_d = STS_TOO_LARGE;
          state_d      = ST_DONE;
        end else if (((over_sum > 33'(limit_q)) || (entry_total_q >= CW'(ENTRIES)))
                     && (entry_total_q != '0)) begin
          rounds_d   = (quarter == '0) ? CW'(1) : quarter;
          idx_d      = '0;
          best_vld_d = 1'b0;
          state_d    = ST_EVICT_RD;
        end else begin
          hash_d  = key_q ^ (key_q >> MIX_SHIFT);
          phase_d = 2'd0;
          mstep_d = 1'b0;
          state_d = ST_HASH_MUL;
        end
      end

      // Find the valid entry with the smallest stamp, lowest slot on ties.
      ST_EVICT_RD: begin
        mem_re  = 1'b1;
        state_d = ST_EVICT_CMP;
      end

      ST_EVICT_CMP: begin
        if (valid_q[idx_q] && (!best_vld_q || (rdata_q.stamp < best_stamp_q))) begin
          best_vld_d   = 1'b1;
          best_idx_d   = idx_q;
          best_stamp_d = rdata_q.stamp;
          best_bytes_d = rdata_q.bytes;
        end
        if (idx_q == LAST_IDX) begin
          state_d = ST_EVICT_DROP;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = ST_EVICT_RD;
        end
      end

      // Remove the victim and decide on another round.
      ST_EVICT_DROP: begin
        if (best_vld_q) begin
          valid_d[best_idx_q] = 1'b0;
          bytes_total_d = (32'(best_bytes_q) <= bytes_total_q) ?
                          (bytes_total_q - 32'(best_bytes_q)) : 32'd0;
          if (entry_total_q != '0) begin
            entry_total_d = entry_total_q - 1'b1;
          end
          evcnt_d = evcnt_q + 1'b1;
        end
        if (!best_vld_q || ((CW + 1)'(evcnt_q) + 1'b1 >= (CW + 1)'(rounds_q))) begin
          hash_d  = key_q ^ (key_q >> MIX_SHIFT);
          phase_d = 2'd0;
          mstep_d = 1'b0;
          state_d = ST_HASH_MUL;
        end else begin
          idx_d      = '0;
          best_vld_d = 1'b0;
          state_d    = ST_EVICT_RD;
        end
      end

      // Low 64 bits of hash times constant from three partial products.
      ST_HASH_MUL: begin
        prod_d  = 64'(mul_a) * 64'(mul_b);
        phase_d = phase_q + 2'd1;
        unique case (phase_q)
          2'd0: ;
          2'd1: acc_d = prod_q;
          2'd2: acc_d = mul_fin;
          default: begin
            phase_d = 2'd0;
            if (!mstep_q) begin
              hash_d  = mix_next;
              mstep_d = 1'b1;
            end else begin
              // Modulo BUCKETS, then modulo ENTRIES: masks of the final hash.
              idx_d   = IW'(mix_next & 64'(BUCKETS - 1));
              step_d  = '0;
              state_d = ST_PROBE;
            end
          end
        endcase
      end

      // Linear probe for a free slot.
      ST_PROBE: begin
        if (!valid_q[idx_q]) begin
          state_d = ST_INSERT;
        end else if (step_q == LAST_IDX) begin
          res_status_d = STS_INSERTED;
          state_d      = ST_DONE;
        end else begin
          idx_d  = (idx_q == LAST_IDX) ? '0 : (idx_q + 1'b1);
          step_d = step_q + 1'b1;
        end
      end

      ST_INSERT: begin
        mem_we          = 1'b1;
        mem_wdata.key   = key_q;
        mem_wdata.stamp = 64'd0;
        mem_wdata.bytes = cnt_bytes;
        valid_d[idx_q]  = 1'b1;
        bytes_total_d   = add_sum[32] ? 32'hFFFF_FFFF : add_sum[31:0];
        entry_total_d   = entry_total_q + 1'b1;
        res_status_d    = STS_INSERTED;
        state_d         = ST_DONE;
      end

      // Hand the result to the output register once it is free.
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase

    out_valid_d = out_load ? 1'b1 : (out_valid_q && out_stall_i);
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      limit_q       <= LIMIT_RESET;
      valid_q       <= '0;
      use_clock_q   <= '0;
      bytes_total_q <= '0;
      entry_total_q <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      limit_q       <= limit_d;
      valid_q       <= valid_d;
      use_clock_q   <= use_clock_d;
      bytes_total_q <= bytes_total_d;
      entry_total_q <= entry_total_d;
      out_valid_q   <= out_valid_d;
    end
  end

  // Working registers.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      kind_q <= kind_e'(kind_i);
      key_q  <= {font_size_i, codepoint_i};
      gw_q   <= glyph_width_i;
      gh_q   <= glyph_height_i;
      bm_q   <= has_bitmap_i;
    end
    idx_q        <= idx_d;
    step_q       <= step_d;
    res_status_q <= res_status_d;
    evcnt_q      <= evcnt_d;
    rounds_q     <= rounds_d;
    best_vld_q   <= best_vld_d;
    best_idx_q   <= best_idx_d;
    best_stamp_q <= best_stamp_d;
    best_bytes_q <= best_bytes_d;
    hash_q       <= hash_d;
    acc_q        <= acc_d;
    prod_q       <= prod_d;
    phase_q      <= phase_d;
    mstep_q      <= mstep_d;
    if (out_load) begin
      out_status_q  <= res_status_q;
      out_evict_q   <= 7'(evcnt_q);
      out_entries_q <= 9'(entry_total_q);
      out_bytes_q   <= bytes_total_q;
    end
  end

  // Tag memory with registered read.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem_q[mem_raddr];
    end
  end

`include "assert_macros.svh"

  `GCL_ASSERT(a_accept_leaves_idle, in_accept |=> (state_q != ST_IDLE))
  `GCL_ASSERT(a_count_matches_valid, $countones(valid_q) == entry_total_q)
  `GCL_ASSERT(a_insert_free_slot, (state_q == ST_INSERT) |-> !valid_q[idx_q])
  `GCL_ASSERT(a_count_bound, entry_total_q <= CW'(ENTRIES))
  `GCL_ASSERT_ALWAYS(a_pready_high, pready)

endmodule

// ===== dv/glyph_tag_checker.sv =====
// Checker for the glyph cache tag engine: predicts every result and compares it.
`timescale 1ns / 100ps

module glyph_tag_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [1:0]  kind_i,
  input  logic [31:0] font_size_i,
  input  logic [31:0] codepoint_i,
  input  logic [9:0]  glyph_width_i,
  input  logic [9:0]  glyph_height_i,
  input  logic        has_bitmap_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [2:0]  status_i,
  input  logic [6:0]  evicted_count_i,
  input  logic [8:0]  entries_in_use_i,
  input  logic [31:0] bytes_in_use_i,
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic [2:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  input  logic        pready_i,
  output int          fail_count_o,
  output int          pending_o
);
  import gcl_pkg::*;

  localparam int TAG_SLOTS = ENTRIES;

  typedef struct packed {
    status_e     status;
    logic [6:0]  evicted;
    logic [8:0]  entries;
    logic [31:0] bytes;
  } tag_report_t;

  // Shadow copy of the tag table.
  logic        slot_valid [TAG_SLOTS];
  logic [63:0] slot_key   [TAG_SLOTS];
  logic [63:0] slot_stamp [TAG_SLOTS];
  logic [31:0] slot_bytes [TAG_SLOTS];
  logic [63:0] use_tick;
  logic [31:0] byte_sum;
  logic [8:0]  live_count;
  logic [24:0] byte_budget;

  tag_report_t reports_due[$];

  assign pending_o = reports_due.size();

  // fmix64 of the key, reduced to a slot.
  function automatic int home_of(logic [63:0] k);
    k = k ^ (k >> MIX_SHIFT);
    k = k * MIX_A;
    k = k ^ (k >> MIX_SHIFT);
    k = k * MIX_B;
    k = k ^ (k >> MIX_SHIFT);
    return int'((k % 64'(BUCKETS)) % 64'(ENTRIES));
  endfunction

  function automatic int find_slot(logic [63:0] k);
    for (int i = 0; i < TAG_SLOTS; i++) begin
      if (slot_valid[i] && slot_key[i] == k) return i;
    end
    return -1;
  endfunction

  // Removes one slot; the byte total saturates at zero.
  task automatic drop_slot(int s);
    slot_valid[s] = 1'b0;
    if (slot_bytes[s] <= byte_sum) byte_sum = byte_sum - slot_bytes[s];
    else byte_sum = '0;
    if (live_count > 0) live_count = live_count - 1;
  endtask

  // Evicts the oldest quarter, at least one; ties go to the lowest slot.
  task automatic evict_oldest(output int dropped);
    int n;
    int best;
    dropped = 0;
    if (live_count == 0) return;
    n = live_count >> 2;
    if (n < 1) n = 1;
    for (int k = 0; k < n; k++) begin
      best = -1;
      for (int i = 0; i < TAG_SLOTS; i++) begin
        if (slot_valid[i] && (best < 0 || slot_stamp[i] < slot_stamp[best])) best = i;
      end
      if (best < 0) break;
      drop_slot(best);
      dropped++;
    end
  endtask

  task automatic predict_tag_op(input kind_e kind, input logic [63:0] key,
                                input logic [9:0] w, input logic [9:0] h,
                                input logic bm, output tag_report_t rep);
    int          s;
    int          dropped;
    logic [31:0] gsize;
    logic [31:0] cnt;
    int          p;
    rep = '0;
    rep.status = STS_MISS;
    dropped = 0;
    case (kind)
      KIND_LOOKUP: begin
        s = find_slot(key);
        if (s >= 0) begin
          use_tick = use_tick + 1;
          slot_stamp[s] = use_tick;
          rep.status = STS_HIT;
        end
      end
      KIND_INSERT: begin
        gsize = (w != 0 && h != 0) ? 32'(w) * 32'(h) : 32'd0;
        if (find_slot(key) >= 0) begin
          rep.status = STS_PRESENT;
        end else if (gsize > 32'(byte_budget)) begin
          rep.status = STS_TOO_LARGE;
        end else begin
          if (33'(byte_sum) + 33'(gsize) > 33'(byte_budget) || live_count >= TAG_SLOTS)
            evict_oldest(dropped);
          p = home_of(key);
          for (int i = 0; i < TAG_SLOTS && slot_valid[p]; i++) p = (p + 1) % TAG_SLOTS;
          if (!slot_valid[p]) begin
            cnt = bm ? gsize : 32'd0;
            slot_valid[p] = 1'b1;
            slot_key[p]   = key;
            slot_stamp[p] = '0;
            slot_bytes[p] = cnt;
            if (32'hFFFF_FFFF - byte_sum < cnt) byte_sum = 32'hFFFF_FFFF;
            else byte_sum = byte_sum + cnt;
            live_count = live_count + 1;
          end
          rep.status = STS_INSERTED;
        end
      end
      KIND_CLEAR: begin
        for (int i = 0; i < TAG_SLOTS; i++) slot_valid[i] = 1'b0;
        live_count = '0;
        byte_sum   = '0;
        rep.status = STS_CLEARED;
      end
      default: ;
    endcase
    rep.evicted = 7'(dropped);
    rep.entries = live_count;
    rep.bytes   = byte_sum;
  endtask

  // Watch the register port and both channels on every edge.
  always @(posedge clk_i or negedge rst_ni) begin
    tag_report_t want;
    tag_report_t got;
    if (!rst_ni) begin
      for (int i = 0; i < TAG_SLOTS; i++) slot_valid[i] = 1'b0;
      use_tick     = '0;
      byte_sum     = '0;
      live_count   = '0;
      byte_budget  = LIMIT_RESET;
      fail_count_o = 0;
      reports_due.delete();
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i && paddr_i[2] == REG_MEMORY_LIMIT)
        byte_budget = pwdata_i[24:0];
      if (out_valid_i && !out_stall_i) begin
        got.status  = status_e'(status_i);
        got.evicted = evicted_count_i;
        got.entries = entries_in_use_i;
        got.bytes   = bytes_in_use_i;
        if (reports_due.size() == 0) begin
          $error("result beat with no prediction waiting");
          fail_count_o++;
        end else begin
          want = reports_due.pop_front();
          if (got.status != want.status) begin
            $error("status expected %0d got %0d", want.status, got.status);
            fail_count_o++;
          end
          if (got.evicted != want.evicted) begin
            $error("evicted_count expected %0d got %0d", want.evicted, got.evicted);
            fail_count_o++;
          end
          if (got.entries != want.entries) begin
            $error("entries_in_use expected %0d got %0d", want.entries, got.entries);
            fail_count_o++;
          end
          if (got.bytes != want.bytes) begin
            $error("bytes_in_use expected %0d got %0d", want.bytes, got.bytes);
            fail_count_o++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        predict_tag_op(kind_e'(kind_i), {font_size_i, codepoint_i}, glyph_width_i,
                       glyph_height_i, has_bitmap_i, want);
        reports_due.push_back(want);
      end
    end
  end

endmodule

// ===== dv/tb_glyph_cache_lru_tag_engine_core.sv =====
// Top of the glyph cache tag engine testbench: stimulus, register phases and verdict.
`timescale 1ns / 100ps

module tb_glyph_cache_lru_tag_engine_core;
  import gcl_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  kind = KIND_LOOKUP;
  logic [31:0] font_size = '0;
  logic [31:0] codepoint = '0;
  logic [9:0]  glyph_width = '0;
  logic [9:0]  glyph_height = '0;
  logic        has_bitmap = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  status;
  logic [6:0]  evicted_count;
  logic [8:0]  entries_in_use;
  logic [31:0] bytes_in_use;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  int          fail_count;
  int          pending;

  // Shared between the sender and the receiver.
  bit          no_idle = 1'b0;
  bit          hold_req = 1'b0;

  // Key pool for the current phase, so that lookups and inserts collide.
  logic [31:0] pool_font_size [512];
  logic [31:0] pool_codepoint [512];

  always #1 clk_i = ~clk_i;

  glyph_cache_lru_tag_engine_core dut (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .kind_i(kind), .font_size_i(font_size), .codepoint_i(codepoint),
    .glyph_width_i(glyph_width), .glyph_height_i(glyph_height),
    .has_bitmap_i(has_bitmap),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .status_o(status), .evicted_count_o(evicted_count),
    .entries_in_use_o(entries_in_use), .bytes_in_use_o(bytes_in_use),
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  glyph_tag_checker u_checker (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_stall_i(in_stall), .kind_i(kind),
    .font_size_i(font_size), .codepoint_i(codepoint),
    .glyph_width_i(glyph_width), .glyph_height_i(glyph_height),
    .has_bitmap_i(has_bitmap),
    .out_valid_i(out_valid), .out_stall_i(out_stall), .status_i(status),
    .evicted_count_i(evicted_count), .entries_in_use_i(entries_in_use),
    .bytes_in_use_i(bytes_in_use),
    .psel_i(psel), .penable_i(penable), .pwrite_i(pwrite), .paddr_i(paddr),
    .pwdata_i(pwdata), .pready_i(pready),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  function automatic int pick_gap();
    if (no_idle) return 0;
    if ($urandom_range(0, 9) < 8) return $urandom_range(0, 2);
    return $urandom_range(10, 60);
  endfunction

  // Offers one beat and returns at the edge that accepts it.
  task automatic send_glyph_op(input kind_e k, input logic [31:0] sb, input logic [31:0] cp,
                               input logic [9:0] w, input logic [9:0] h, input logic bm);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid     <= 1'b1;
    kind         <= k;
    font_size    <= sb;
    codepoint    <= cp;
    glyph_width  <= w;
    glyph_height <= h;
    has_bitmap   <= bm;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
  endtask

  // Lowers valid and waits until every predicted result has come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // Register write: setup cycle, then access cycle.
  task automatic write_budget(input logic [31:0] value);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    paddr   <= {REG_MEMORY_LIMIT, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic fill_pool(input int n);
    for (int i = 0; i < n; i++) begin
      pool_font_size[i] = $urandom();
      pool_codepoint[i] = $urandom();
    end
  endtask

  // One random phase: mostly pooled keys, some fresh keys, few clears.
  task automatic random_phase(input int items, input int pool_n, input int clear_pct,
                              input int bm_pct, input int dim_max);
    kind_e       k;
    int          r;
    int          idx;
    logic [31:0] sb;
    logic [31:0] cp;
    logic [9:0]  w;
    logic [9:0]  h;
    fill_pool(pool_n);
    for (int n = 0; n < items; n++) begin
      r = $urandom_range(0, 99);
      if (r < clear_pct) k = KIND_CLEAR;
      else if (r < clear_pct + 2) k = KIND_RSVD;
      else if (r < 55) k = KIND_LOOKUP;
      else k = KIND_INSERT;
      idx = $urandom_range(0, pool_n - 1);
      sb = pool_font_size[idx];
      cp = pool_codepoint[idx];
      if ($urandom_range(0, 9) == 0) begin
        sb = $urandom();
        cp = $urandom();
      end
      if ($urandom_range(0, 19) == 0) begin
        w = $urandom_range(0, 1023);
        h = $urandom_range(0, 1023);
      end else begin
        w = $urandom_range(0, dim_max);
        h = $urandom_range(0, dim_max);
      end
      if (n % 40 == 20) no_idle = ~no_idle;
      send_glyph_op(k, sb, cp, w, h, $urandom_range(0, 99) < bm_pct);
    end
    no_idle = 1'b0;
    drain_results();
  endtask

  // Receiver: random stalls, plus one long hold on request.
  initial begin
    int run;
    forever begin
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (3000) @(posedge clk_i);
        hold_req = 1'b0;
      end else if (no_idle) begin
        out_stall <= 1'b0;
        @(posedge clk_i);
      end else begin
        out_stall <= ($urandom_range(0, 3) == 0);
        run = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 200) : $urandom_range(1, 3);
        repeat (run) @(posedge clk_i);
      end
    end
  end

  // Ends a hung run.
  initial begin
    #500_000_000;
    $display("tb_glyph_cache_lru_tag_engine_core: FAIL");
    $finish;
  end

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part at the reset budget.
    send_glyph_op(KIND_LOOKUP, 32'h0, 32'h0, 10'd0, 10'd0, 1'b0);
    send_glyph_op(KIND_INSERT, 32'h0, 32'h0, 10'd0, 10'd0, 1'b1);
    send_glyph_op(KIND_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 10'd1023, 10'd1023, 1'b1);
    send_glyph_op(KIND_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 10'd5, 10'd5, 1'b1);
    send_glyph_op(KIND_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 10'd0, 10'd0, 1'b0);
    send_glyph_op(KIND_LOOKUP, 32'h0, 32'h0, 10'd1023, 10'd1023, 1'b1);
    send_glyph_op(KIND_INSERT, 32'h4140_0000, 32'h41, 10'd1023, 10'd0, 1'b1);
    send_glyph_op(KIND_INSERT, 32'h4140_0000, 32'h42, 10'd12, 10'd16, 1'b0);
    send_glyph_op(KIND_RSVD, 32'hFFFF_FFFF, 32'h0, 10'd1023, 10'd1023, 1'b1);
    send_glyph_op(KIND_CLEAR, 32'h0, 32'h0, 10'd0, 10'd0, 1'b0);
    send_glyph_op(KIND_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 10'd0, 10'd0, 1'b0);
    drain_results();

    // Smallest budget: rejection and byte-driven eviction.
    write_budget(32'd1);
    send_glyph_op(KIND_INSERT, 32'h1, 32'h1, 10'd1, 10'd1, 1'b1);
    send_glyph_op(KIND_INSERT, 32'h1, 32'h2, 10'd1, 10'd2, 1'b1);
    send_glyph_op(KIND_INSERT, 32'h1, 32'h3, 10'd1, 10'd1, 1'b1);
    send_glyph_op(KIND_INSERT, 32'h1, 32'h4, 10'd0, 10'd9, 1'b1);
    send_glyph_op(KIND_LOOKUP, 32'h1, 32'h3, 10'd0, 10'd0, 1'b0);
    drain_results();

    // Largest budget with the biggest glyphs.
    write_budget(32'd16777216);
    for (int i = 0; i < 18; i++)
      send_glyph_op(KIND_INSERT, 32'h2, 32'(i), 10'd1023, 10'd1023, 1'b1);
    drain_results();

    // Random phases; the first one also holds the receiver off for a long stretch.
    hold_req = 1'b1;
    write_budget(32'd4194304);
    random_phase(260, 48, 3, 60, 63);
    write_budget(32'd20000);
    random_phase(260, 40, 2, 80, 63);
    write_budget(32'd16777216);
    random_phase(360, 400, 0, 10, 31);
    write_budget(32'd1);
    random_phase(150, 16, 3, 50, 2);
    write_budget(32'd300000);
    random_phase(260, 64, 3, 70, 200);
    write_budget(32'd16777216);
    random_phase(260, 64, 2, 90, 1023);

    drain_results();
    repeat (20) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("tb_glyph_cache_lru_tag_engine_core: PASS");
    end else begin
      $display("tb_glyph_cache_lru_tag_engine_core: FAIL");
    end
    $finish;
  end

endmodule
